// File: rtl/core/ist_pkg.sv
package ist_pkg;

    localparam int STAMP_W = 48;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 64;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_RESET = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic [STAMP_W-1:0] last_stamp;
        logic               first_pending;
        logic [VAL_W-1:0]   min_seen;
        logic [VAL_W-1:0]   max_seen;
        logic [SUM_W-1:0]   interval_sum;
        logic [VAL_W-1:0]   interval_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        last_stamp:     '0,
        first_pending:  1'b1,
        min_seen:       '1,
        max_seen:       '0,
        interval_sum:   '0,
        interval_count: '0
    };

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

// File: rtl/core/ist_ram.sv
module ist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/interval_statistics_table.sv
// Per-channel interval statistics. Each slave transfer carries an op in tuser
// (mark, reset channel, read statistics) and a channel and 48-bit ns timestamp
// in tdata; only a read returns a master transfer (has_data in tuser, min, max,
// average and count in tdata). The statistics live in one RAM entry per channel
// with a valid bit each, so no clearing pass follows reset. Items are handled
// one at a time: a reset or an unused op is handled in the idle state, a mark
// goes through RAM read, interval and write-back, and a read through RAM read,
// the radix-2 divider's 32 iterations when the average needs them, and output;
// a read also waits while the previous result is still held on the master side.
module interval_statistics_table #(
    parameter int CHANNELS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [55:0]  i_s_axis_tdata,   // channel[1:0], timestamp[49:2], zero pad
    input  logic [1:0]   i_s_axis_tuser,   // op[1:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // min, max, avg, sample_count (32 b each)
    output logic         o_m_axis_tuser    // has_data
);

    import ist_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state               r_state;
    t_op                  r_op;
    logic [AW-1:0]        r_addr;
    logic                 r_ch_ok;
    logic [STAMP_W-1:0]   r_ts;
    t_entry               r_entry;
    logic [VAL_W-1:0]     r_iv;
    logic [CHANNELS-1:0]  r_valid;
    logic [4:0]           r_div_cnt;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W-1:0]     r_quo;
    logic                 r_res_has;
    logic                 r_out_valid;
    logic [127:0]         r_out_data;
    logic                 r_out_has;

    logic                 s_fire;
    logic                 m_fire;
    logic [1:0]           in_channel;
    logic [AW-1:0]        in_addr;
    logic                 in_ok;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               n_entry_rd;
    logic [STAMP_W-1:0]   n_diff;
    t_entry               n_entry_wb;
    logic [SUM_W:0]       n_sum;
    logic [VAL_W:0]       n_rem2;
    logic                 n_ge;
    logic [VAL_W:0]       n_rem_sub;
    logic                 ram_we;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign m_fire          = r_out_valid && i_m_axis_tready;
    assign in_channel      = i_s_axis_tdata[1:0];
    assign in_addr         = AW'(in_channel);
    assign in_ok           = (32'(in_channel) < 32'(CHANNELS));
    assign ram_we          = (r_state == S_UPDATE);

    ist_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (n_entry_wb),
        .i_re    (s_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_entry_rd = (r_ch_ok && r_valid[r_addr]) ? t_entry'(ram_rdata) : ENTRY_RESET;
        n_diff     = r_ts - n_entry_rd.last_stamp;
    end

    always_comb begin
        n_entry_wb = r_entry;
        n_sum      = {1'b0, r_entry.interval_sum} + {{(SUM_W-VAL_W+1){1'b0}}, r_iv};
        n_entry_wb.last_stamp    = r_ts;
        n_entry_wb.first_pending = 1'b0;
        if (!r_entry.first_pending) begin
            if (r_iv < r_entry.min_seen) begin
                n_entry_wb.min_seen = r_iv;
            end
            if (r_iv > r_entry.max_seen) begin
                n_entry_wb.max_seen = r_iv;
            end
            n_entry_wb.interval_sum = n_sum[SUM_W] ? '1 : n_sum[SUM_W-1:0];
            if (r_entry.interval_count != '1) begin
                n_entry_wb.interval_count = r_entry.interval_count + 1'b1;
            end
        end
    end

    always_comb begin
        n_rem2    = {r_rem, r_quo[VAL_W-1]};
        n_ge      = (n_rem2 >= {1'b0, r_entry.interval_count});
        n_rem_sub = n_rem2 - {1'b0, r_entry.interval_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        priority if (t_op'(i_s_axis_tuser) == OP_READ) begin
                            r_state <= S_LOAD;
                        end else if (t_op'(i_s_axis_tuser) == OP_MARK && in_ok) begin
                            r_state <= S_LOAD;
                        end else if (t_op'(i_s_axis_tuser) == OP_RESET && in_ok) begin
                            r_valid[in_addr] <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LOAD: begin
                    priority if (r_op == OP_MARK) begin
                        r_state <= S_UPDATE;
                    end else if (!r_ch_ok || n_entry_rd.interval_count == '0) begin
                        r_state <= S_DONE;
                    end else if (n_entry_rd.interval_sum[SUM_W-1:VAL_W]
                                 >= n_entry_rd.interval_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_UPDATE: begin
                    r_valid[r_addr] <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op    <= t_op'(i_s_axis_tuser);
            r_addr  <= in_addr;
            r_ch_ok <= in_ok;
            r_ts    <= i_s_axis_tdata[49:2];
        end
        if (r_state == S_LOAD) begin
            r_entry   <= n_entry_rd;
            r_iv      <= (|n_diff[STAMP_W-1:VAL_W]) ? '1 : n_diff[VAL_W-1:0];
            r_res_has <= r_ch_ok && (n_entry_rd.interval_count != '0);
            r_rem     <= n_entry_rd.interval_sum[SUM_W-1:VAL_W];
            r_div_cnt <= '1;
            if (n_entry_rd.interval_sum[SUM_W-1:VAL_W] >= n_entry_rd.interval_count) begin
                r_quo <= '1;
            end else begin
                r_quo <= n_entry_rd.interval_sum[VAL_W-1:0];
            end
        end
        if (r_state == S_DIV) begin
            r_rem     <= n_ge ? n_rem_sub[VAL_W-1:0] : n_rem2[VAL_W-1:0];
            r_quo     <= {r_quo[VAL_W-2:0], n_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (r_state == S_DONE && (!r_out_valid || i_m_axis_tready)) begin
            r_out_has <= r_res_has;
            if (r_res_has) begin
                r_out_data <= {r_entry.interval_count, r_quo,
                               r_entry.max_seen, r_entry.min_seen};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_has;

endmodule
